@@ src/glw_pkg.sv @@
// Shared types, constants and helpers for the grid line walker.
package glw_pkg;

  localparam int GridSize   = 64;
  localparam int CoordW     = 6;
  localparam int ErrW       = CoordW + 3;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  typedef logic [CoordW-1:0] coord_t;
  typedef logic signed [ErrW-1:0] err_t;

  // One classified line, ready for the walker.
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   x_major;
    logic   step_x_neg;
    logic   step_y_neg;
    coord_t major;
    coord_t minor;
    err_t   err;
  } walk_desc_t;

  function automatic coord_t clamp_coord(coord_t v);
    coord_t c;
    c = v;
    if ({1'b0, v} > (CoordW+1)'(GridSize - 1)) begin
      c = coord_t'(GridSize - 1);
    end
    return c;
  endfunction

endpackage

@@ src/glw_front.sv @@
// Front end: clamps a request, finds the octant and the initial error term.
module glw_front (
  input  glw_pkg::coord_t     start_x_i,
  input  glw_pkg::coord_t     start_y_i,
  input  glw_pkg::coord_t     end_x_i,
  input  glw_pkg::coord_t     end_y_i,
  input  logic                accept_i,
  output glw_pkg::walk_desc_t desc_o,
  output logic                desc_valid_o
);

  glw_pkg::coord_t sx, sy, ex, ey;
  glw_pkg::coord_t adx, ady;
  logic            x_ge, y_ge, x_major;

  always_comb begin
    sx = glw_pkg::clamp_coord(start_x_i);
    sy = glw_pkg::clamp_coord(start_y_i);
    ex = glw_pkg::clamp_coord(end_x_i);
    ey = glw_pkg::clamp_coord(end_y_i);
    x_ge = (ex >= sx);
    y_ge = (ey >= sy);
    adx = x_ge ? (ex - sx) : (sx - ex);
    ady = y_ge ? (ey - sy) : (sy - ey);
    x_major = (adx >= ady);

    desc_o.x          = sx;
    desc_o.y          = sy;
    desc_o.x_major    = x_major;
    desc_o.step_x_neg = ~x_ge;
    desc_o.step_y_neg = ~y_ge;
    desc_o.major      = x_major ? adx : ady;
    desc_o.minor      = x_major ? ady : adx;
    // err = 2*minor - major
    desc_o.err = $signed({2'b00, desc_o.minor, 1'b0}) - $signed({3'b000, desc_o.major});
  end

  // zero-length lines produce nothing and are dropped here
  assign desc_valid_o = accept_i && (desc_o.major != '0);

endmodule

@@ src/glw_queue.sv @@
// Short descriptor queue between front end and walker.
module glw_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_i,
  input  glw_pkg::walk_desc_t wr_data_i,
  input  logic                rd_i,
  output glw_pkg::walk_desc_t rd_data_o,
  output logic                full_o,
  output logic                empty_o
);

  glw_pkg::walk_desc_t               mem_q [glw_pkg::QueueDepth];
  logic [glw_pkg::QPtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [glw_pkg::QCntW-1:0]         cnt_q;
  logic                              do_wr, do_rd;

  assign full_o  = (cnt_q == glw_pkg::QCntW'(glw_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == glw_pkg::QPtrW'(glw_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == glw_pkg::QPtrW'(glw_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ src/glw_back.sv @@
// Back end: walks one line a cell per cycle into the output register, stalling while an unpopped cell is held there.
module glw_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  glw_pkg::walk_desc_t desc_i,
  input  logic                desc_empty_i,
  output logic                desc_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output glw_pkg::coord_t     cell_x_o,
  output glw_pkg::coord_t     cell_y_o,
  output logic                final_cell_o
);

  logic                busy_q, busy_d;
  logic                out_valid_q, out_valid_d;
  glw_pkg::walk_desc_t cur_q, cur_d;
  glw_pkg::coord_t     cnt_q, cnt_d;
  glw_pkg::coord_t     cell_x_q, cell_x_d, cell_y_q, cell_y_d;
  logic                final_q, final_d;
  logic                load, step;
  logic                minor_step;
  glw_pkg::err_t       two_major, two_minor;
  glw_pkg::coord_t     nx, ny;

  assign load       = !busy_q && !desc_empty_i;
  assign step       = busy_q && (!out_valid_q || pop_i);
  assign desc_pop_o = load;

  always_comb begin
    two_major  = $signed({2'b00, cur_q.major, 1'b0});
    two_minor  = $signed({2'b00, cur_q.minor, 1'b0});
    minor_step = (cur_q.err > 0);
    nx = cur_q.x;
    ny = cur_q.y;
    if (cur_q.x_major || minor_step) begin
      nx = cur_q.step_x_neg ? cur_q.x - 1'b1 : cur_q.x + 1'b1;
    end
    if (!cur_q.x_major || minor_step) begin
      ny = cur_q.step_y_neg ? cur_q.y - 1'b1 : cur_q.y + 1'b1;
    end

    busy_d      = busy_q;
    cur_d       = cur_q;
    cnt_d       = cnt_q;
    cell_x_d    = cell_x_q;
    cell_y_d    = cell_y_q;
    final_d     = final_q;
    out_valid_d = out_valid_q && !pop_i;

    if (load) begin
      busy_d = 1'b1;
      cur_d  = desc_i;
      cnt_d  = desc_i.major;
    end else if (step) begin
      cur_d.x   = nx;
      cur_d.y   = ny;
      cur_d.err = minor_step ? cur_q.err - two_major + two_minor : cur_q.err + two_minor;
      cnt_d     = cnt_q - 1'b1;
      cell_x_d  = nx;
      cell_y_d  = ny;
      final_d   = (cnt_q == glw_pkg::coord_t'(1));
      out_valid_d = 1'b1;
      if (cnt_q == glw_pkg::coord_t'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    cnt_q    <= cnt_d;
    cell_x_q <= cell_x_d;
    cell_y_q <= cell_y_d;
    final_q  <= final_d;
  end

  assign empty_o      = !out_valid_q;
  assign cell_x_o     = cell_x_q;
  assign cell_y_o     = cell_y_q;
  assign final_cell_o = final_q;

endmodule

@@ src/grid_line_walker_top.sv @@
// A taken request passes the descriptor queue, then the walker's descriptor
// register. Cells follow at one per cycle while the output is popped; a line
// of span N takes one load step, then N cells, before the next line loads.
// A two-entry descriptor queue lets requests be taken while a line walks.
// Reset (rst_ni low, asynchronous) empties the queue and the output register.
// Top level of the grid line walker.
module grid_line_walker_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push,
  output logic            full,
  input  glw_pkg::coord_t start_x_i,
  input  glw_pkg::coord_t start_y_i,
  input  glw_pkg::coord_t end_x_i,
  input  glw_pkg::coord_t end_y_i,
  output logic            empty,
  input  logic            pop,
  output glw_pkg::coord_t cell_x_o,
  output glw_pkg::coord_t cell_y_o,
  output logic            final_cell_o
);

  glw_pkg::walk_desc_t front_desc, queue_desc;
  logic                front_valid, queue_empty, queue_pop;
  logic                accept, out_pop;

  assign accept  = push && !full;
  assign out_pop = pop && !empty;

  glw_front u_front (
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .accept_i     (accept),
    .desc_o       (front_desc),
    .desc_valid_o (front_valid)
  );

  glw_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_valid),
    .wr_data_i (front_desc),
    .rd_i      (queue_pop),
    .rd_data_o (queue_desc),
    .full_o    (full),
    .empty_o   (queue_empty)
  );

  glw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (queue_desc),
    .desc_empty_i (queue_empty),
    .desc_pop_o   (queue_pop),
    .pop_i        (out_pop),
    .empty_o      (empty),
    .cell_x_o     (cell_x_o),
    .cell_y_o     (cell_y_o),
    .final_cell_o (final_cell_o)
  );

endmodule
